/* design/lac_pkg.sv */
// Shared types and constants of the IP local address classifier.
// No dependencies; every other source file uses this package.
package lac_pkg;

   localparam int NUM_IFACES = 8;
   localparam int IDX_W      = 3;
   localparam int ADDR_W     = 32;
   localparam int OP_W       = 2;
   localparam int CLS_W      = 2;
   localparam int FLAG_W     = 3;
   localparam int KIND_W     = 2;
   localparam int Q_DEPTH    = 2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_IFACES - 1);

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
   localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND     = 2'd2;

   // address classes
   localparam logic [CLS_W-1:0] CLS_NONE  = 2'd0;
   localparam logic [CLS_W-1:0] CLS_BCAST = 2'd1;
   localparam logic [CLS_W-1:0] CLS_MINE  = 2'd2;

   // flag bit positions
   localparam int FLAG_UP   = 0;
   localparam int FLAG_LOOP = 1;
   localparam int FLAG_PTP  = 2;

   // job kinds passed from front to back
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_IMM   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLS   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FIND  = 2'd3;

   localparam logic [ADDR_W-1:0] ALL_ONES = '1;
   localparam logic [7:0]        LOOP_NET = 8'h7F;
   localparam logic [ADDR_W-1:0] HOST_A   = 32'h00FF_FFFF;
   localparam logic [ADDR_W-1:0] HOST_B   = 32'h0000_FFFF;
   localparam logic [ADDR_W-1:0] HOST_C   = 32'h0000_00FF;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CLS_W-1:0]  imm_class;
      logic [IDX_W-1:0]  index;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] peer;
      logic [FLAG_W-1:0] flags;
      logic [ADDR_W-1:0] query;
      logic [ADDR_W-1:0] host;
   } lac_cmd_type;

endpackage

/* design/lac_req_if.sv */
// Request channel: valid/ready handshake with the request beat payload.
// Depends on lac_pkg.
interface lac_req_if;
   logic                      valid;
   logic                      ready;
   logic [lac_pkg::OP_W-1:0]   operation;
   logic [lac_pkg::IDX_W-1:0]  entry_index;
   logic [lac_pkg::ADDR_W-1:0] entry_addr;
   logic [lac_pkg::ADDR_W-1:0] entry_mask;
   logic [lac_pkg::ADDR_W-1:0] entry_peer;
   logic                      entry_up;
   logic                      entry_loopback;
   logic                      entry_ptp;
   logic [lac_pkg::ADDR_W-1:0] query_addr;

   modport source (
      output valid, operation, entry_index, entry_addr, entry_mask, entry_peer,
      output entry_up, entry_loopback, entry_ptp, query_addr,
      input  ready
   );
   modport sink (
      input  valid, operation, entry_index, entry_addr, entry_mask, entry_peer,
      input  entry_up, entry_loopback, entry_ptp, query_addr,
      output ready
   );
endinterface

/* design/lac_rsp_if.sv */
// Response channel: valid/ready handshake with the result beat payload.
// Depends on lac_pkg.
interface lac_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lac_pkg::CLS_W-1:0]  addr_class;
   logic                      found;
   logic [lac_pkg::IDX_W-1:0]  found_index;

   modport source (
      output valid, addr_class, found, found_index,
      input  ready
   );
   modport sink (
      input  valid, addr_class, found, found_index,
      output ready
   );
endinterface

/* design/lac_front.sv */
// Front end: accepts request beats, settles fixed-answer cases and builds jobs.
// Depends on lac_pkg and lac_req_if.
module lac_front (
   lac_req_if.sink              req_if,
   output logic                 push_valid,
   input  logic                 push_ready,
   output lac_pkg::lac_cmd_type push_data
);
   import lac_pkg::*;

   logic [ADDR_W-1:0] q;

   assign q             = req_if.query_addr;
   assign push_valid    = req_if.valid;
   assign req_if.ready  = push_ready;

   always_comb begin
      push_data.kind      = KIND_IMM;
      push_data.imm_class = CLS_NONE;
      push_data.index     = req_if.entry_index;
      push_data.addr      = req_if.entry_addr;
      push_data.mask      = req_if.entry_mask;
      push_data.peer      = req_if.entry_peer;
      push_data.flags     = {req_if.entry_ptp, req_if.entry_loopback, req_if.entry_up};
      push_data.query     = q;
      // classful host part by the query's class; D and E count as C
      if (!q[ADDR_W-1]) begin
         push_data.host = HOST_A;
      end else if (!q[ADDR_W-2]) begin
         push_data.host = HOST_B;
      end else begin
         push_data.host = HOST_C;
      end
      case (req_if.operation)
         OP_WRITE: begin
            push_data.kind = KIND_WRITE;
         end
         OP_CLASSIFY: begin
            if (q == '0 || q == ALL_ONES) begin
               push_data.imm_class = CLS_BCAST;
            end else if (q[ADDR_W-1 -: 8] == LOOP_NET) begin
               push_data.imm_class = CLS_MINE;
            end else begin
               push_data.kind = KIND_CLS;
            end
         end
         OP_FIND: begin
            push_data.kind = KIND_FIND;
         end
         default: begin
            push_data.kind = KIND_IMM;
         end
      endcase
   end

endmodule

/* design/lac_queue.sv */
// Short job queue between front and back end.
// Depends on lac_pkg.
module lac_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  lac_pkg::lac_cmd_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output lac_pkg::lac_cmd_type pop_data
);
   import lac_pkg::*;

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   lac_cmd_type       slot_ff [Q_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/lac_back.sv */
// Back end: interface table, one-entry-per-cycle scan and result register.
// Depends on lac_pkg and lac_rsp_if.
module lac_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  lac_pkg::lac_cmd_type pop_data,
   lac_rsp_if.source            rsp_if
);
   import lac_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic [ADDR_W-1:0] addr_ff  [NUM_IFACES];
   logic [ADDR_W-1:0] mask_ff  [NUM_IFACES];
   logic [ADDR_W-1:0] peer_ff  [NUM_IFACES];
   logic [FLAG_W-1:0] flags_ff [NUM_IFACES];

   logic              state_ff, state_in;
   lac_cmd_type       job_ff;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              np_found_ff, np_found_in;
   logic [IDX_W-1:0]  np_idx_ff, np_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CLS_W-1:0]  rsp_class_ff, rsp_class_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;

   logic              out_free, rsp_load, pop, is_scan_job, do_write;
   logic [ADDR_W-1:0] a, m, p, q;
   logic [FLAG_W-1:0] f;
   logic              up, net_eq, cls_mine, cls_bc, ptp_hit, np_hit, last, scan_done;

   assign out_free    = !rsp_valid_ff || rsp_if.ready;
   assign is_scan_job = (pop_data.kind == KIND_CLS) || (pop_data.kind == KIND_FIND);
   assign pop_ready   = (state_ff == ST_IDLE) && (is_scan_job || out_free);
   assign pop         = pop_valid && pop_ready;
   assign do_write    = pop && (pop_data.kind == KIND_WRITE)
                        && (int'(pop_data.index) < NUM_IFACES);

   // current table entry under test
   assign a  = addr_ff[scan_ff];
   assign m  = mask_ff[scan_ff];
   assign p  = peer_ff[scan_ff];
   assign f  = flags_ff[scan_ff];
   assign q  = job_ff.query;
   assign up = f[FLAG_UP];

   assign net_eq   = ((q ^ a) & m) == '0;
   assign cls_mine = up && (a == '0 || q == a);
   assign cls_bc   = up && ((net_eq && ((q & ~m) == '0 || (q | m) == ALL_ONES))
                            || q == (a | job_ff.host));
   assign ptp_hit  = up && f[FLAG_PTP] && (q == p);
   assign np_hit   = up && !f[FLAG_PTP] && (f[FLAG_LOOP] ? (q == a) : net_eq);
   assign last     = (scan_ff == LAST_IDX);
   assign scan_done = (job_ff.kind == KIND_CLS) ? (cls_mine || cls_bc || last)
                                               : (ptp_hit || last);

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      np_found_in  = np_found_ff;
      np_idx_in    = np_idx_ff;
      rsp_load     = 1'b0;
      rsp_class_in = CLS_NONE;
      rsp_found_in = 1'b0;
      rsp_idx_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (is_scan_job) begin
                  state_in    = ST_SCAN;
                  scan_in     = '0;
                  np_found_in = 1'b0;
                  np_idx_in   = '0;
               end else begin
                  rsp_load     = 1'b1;
                  rsp_class_in = (pop_data.kind == KIND_IMM) ? pop_data.imm_class : CLS_NONE;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
                  if (job_ff.kind == KIND_CLS) begin
                     rsp_class_in = cls_mine ? CLS_MINE : (cls_bc ? CLS_BCAST : CLS_NONE);
                  end else if (ptp_hit) begin
                     rsp_found_in = 1'b1;
                     rsp_idx_in   = scan_ff;
                  end else if (np_found_ff) begin
                     rsp_found_in = 1'b1;
                     rsp_idx_in   = np_idx_ff;
                  end else if (np_hit) begin
                     rsp_found_in = 1'b1;
                     rsp_idx_in   = scan_ff;
                  end
               end
            end else begin
               scan_in = scan_ff + 1'b1;
               if (job_ff.kind == KIND_FIND && np_hit && !np_found_ff) begin
                  np_found_in = 1'b1;
                  np_idx_in   = scan_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_IFACES; i++) begin
            flags_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_write) begin
            flags_ff[pop_data.index] <= pop_data.flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      np_found_ff <= np_found_in;
      np_idx_ff   <= np_idx_in;
      if (pop) begin
         job_ff <= pop_data;
      end
      if (do_write) begin
         addr_ff[pop_data.index] <= pop_data.addr;
         mask_ff[pop_data.index] <= pop_data.mask;
         peer_ff[pop_data.index] <= pop_data.peer;
      end
      if (rsp_load) begin
         rsp_class_ff <= rsp_class_in;
         rsp_found_ff <= rsp_found_in;
         rsp_idx_ff   <= rsp_idx_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.addr_class  = rsp_class_ff;
   assign rsp_if.found       = rsp_found_ff;
   assign rsp_if.found_index = rsp_idx_ff;

`ifndef SYNTH
   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result loaded over an untaken beat");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == ST_IDLE)
      else $error("job taken while scanning");

   a_scan_enters_at_zero: assert property (@(posedge clock) disable iff (reset)
      (pop && is_scan_job) |=> (state_ff == ST_SCAN && scan_ff == '0))
      else $error("scan did not start at first entry");

   a_class_xor_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_class_ff != CLS_NONE))
      else $error("result carries both a class and a found index");

   a_not_found_zero_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> rsp_idx_ff == '0)
      else $error("index set without a hit");
`endif

endmodule

/* design/ip_local_address_classifier.sv */
// IP local address classifier. A request beat either loads one of eight
// interface entries (address, mask, peer, up/loopback/point-to-point flags),
// classifies an address as broadcast, own address or neither, or finds the
// interface that reaches an address; every beat gives exactly one response.
// Writes, unknown operations and the fixed cases of classify (all zeros,
// all ones, 127/8) pass the two-deep job queue and skip the table scan.
// Table lookups walk the entries in index order, one entry per cycle in the
// back end's compare stage: classify stops at the first deciding entry, find
// at the first point-to-point peer hit or at the last entry, and the final step
// waits while the previous response is untaken. The queue keeps accepting while
// the back end scans or a response waits to be taken, until both of its slots
// hold jobs.
// Depends on lac_pkg, lac_req_if, lac_rsp_if, lac_front, lac_queue, lac_back.
module ip_local_address_classifier (
   input  logic     clock,
   input  logic     reset,
   lac_req_if.sink   req_if,
   lac_rsp_if.source rsp_if
);
   import lac_pkg::*;

   logic        push_valid, push_ready, pop_valid, pop_ready;
   lac_cmd_type push_data, pop_data;

   lac_front u_front (
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   lac_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   lac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_if    (rsp_if)
   );

endmodule

/* sim/tb_ip_local_address_classifier.sv */
// Self-checking testbench of ip_local_address_classifier: directed and random beats of
// interface writes, classify and find lookups, with random idling on both channels.
// Depends on lac_pkg, lac_req_if, lac_rsp_if and the design under test.
module tb_ip_local_address_classifier;
   import lac_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_BEATS = 1300;
   localparam int DRAIN_CYCLES = 20;
   localparam int TIME_LIMIT   = 1000000;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] peer;
      logic              up;
      logic              loopback;
      logic              ptp;
      logic [ADDR_W-1:0] query;
   } req_beat_t;

   typedef struct packed {
      logic [CLS_W-1:0] cls;
      logic             hit;
      logic [IDX_W-1:0] idx;
   } rsp_beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   req_beat_t req_beat  = '0;
   logic      req_valid = 1'b0;
   logic      req_fire  = 1'b0;
   logic      rsp_ready = 1'b0;
   logic [31:0] cycle_count = '0;
   int        req_gap = 0;
   int        rsp_stall = 0;
   int        fail_count = 0;

   req_beat_t pending_req[$];
   rsp_beat_t expected_rsp[$];

   // interface table as the block should hold it
   logic [ADDR_W-1:0] tab_addr [NUM_IFACES];
   logic [ADDR_W-1:0] tab_mask [NUM_IFACES];
   logic [ADDR_W-1:0] tab_peer [NUM_IFACES];
   logic              tab_up   [NUM_IFACES];
   logic              tab_loop [NUM_IFACES];
   logic              tab_ptp  [NUM_IFACES];

   // table as written by the stimulus, used to aim queries
   logic [ADDR_W-1:0] gen_addr [NUM_IFACES];
   logic [ADDR_W-1:0] gen_mask [NUM_IFACES];
   logic [ADDR_W-1:0] gen_peer [NUM_IFACES];

   lac_req_if req_ch ();
   lac_rsp_if rsp_ch ();

   assign req_ch.valid          = req_valid;
   assign req_ch.operation      = req_beat.op;
   assign req_ch.entry_index    = req_beat.idx;
   assign req_ch.entry_addr     = req_beat.addr;
   assign req_ch.entry_mask     = req_beat.mask;
   assign req_ch.entry_peer     = req_beat.peer;
   assign req_ch.entry_up       = req_beat.up;
   assign req_ch.entry_loopback = req_beat.loopback;
   assign req_ch.entry_ptp      = req_beat.ptp;
   assign req_ch.query_addr     = req_beat.query;
   assign rsp_ch.ready          = rsp_ready;

   wire calm_req = (cycle_count[8:7] == 2'b11);
   wire calm_rsp = (cycle_count[9:8] == 2'b10);

   ip_local_address_classifier DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned pick_gap(input logic calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic logic [ADDR_W-1:0] classful_host(input logic [ADDR_W-1:0] a);
      if (!a[31]) return HOST_A;
      if (a[31:30] == 2'b10) return HOST_B;
      return HOST_C;
   endfunction

   function automatic logic [CLS_W-1:0] classify_addr(input logic [ADDR_W-1:0] q);
      logic [ADDR_W-1:0] host, a, m;
      host = classful_host(q);
      if (q == '0 || q == ALL_ONES) return CLS_BCAST;
      if (q[31:24] == LOOP_NET) return CLS_MINE;
      for (int i = 0; i < NUM_IFACES; i++) begin
         a = tab_addr[i];
         m = tab_mask[i];
         if (tab_up[i]) begin
            if (a == '0 || q == a) return CLS_MINE;
            if ((q & m) == (a & m) && ((q & ~m) == '0 || (q | m) == ALL_ONES))
               return CLS_BCAST;
            if (q == (a | host)) return CLS_BCAST;
         end
      end
      return CLS_NONE;
   endfunction

   function automatic rsp_beat_t locate_iface(input logic [ADDR_W-1:0] q);
      rsp_beat_t r;
      logic      hit;
      r = '0;
      for (int i = 0; i < NUM_IFACES; i++) begin
         if (tab_up[i] && tab_ptp[i] && q == tab_peer[i]) begin
            r.hit = 1'b1;
            r.idx = IDX_W'(i);
            return r;
         end
      end
      for (int i = 0; i < NUM_IFACES; i++) begin
         if (tab_up[i] && !tab_ptp[i]) begin
            if (tab_loop[i]) hit = (q == tab_addr[i]);
            else hit = ((q & tab_mask[i]) == (tab_addr[i] & tab_mask[i]));
            if (hit) begin
               r.hit = 1'b1;
               r.idx = IDX_W'(i);
               return r;
            end
         end
      end
      return r;
   endfunction

   task automatic note_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // monitor: checks result beats, predicts each accepted request beat
   always @(posedge clock) begin
      rsp_beat_t got, want;
      req_beat_t b;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         for (int i = 0; i < NUM_IFACES; i++) begin
            tab_addr[i] = '0;
            tab_mask[i] = '0;
            tab_peer[i] = '0;
            tab_up[i]   = 1'b0;
            tab_loop[i] = 1'b0;
            tab_ptp[i]  = 1'b0;
         end
         req_fire <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ready) begin
            got.cls = rsp_ch.addr_class;
            got.hit = rsp_ch.found;
            got.idx = rsp_ch.found_index;
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual %0d/%0d/%0d",
                        $time, got.cls, got.hit, got.idx);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               note_field("addr_class", 32'(want.cls), 32'(got.cls));
               note_field("found", 32'(want.hit), 32'(got.hit));
               note_field("found_index", 32'(want.idx), 32'(got.idx));
            end
         end
         if (req_valid && req_ch.ready) begin
            b = req_beat;
            want = '0;
            case (b.op)
               OP_WRITE: begin
                  tab_addr[b.idx] = b.addr;
                  tab_mask[b.idx] = b.mask;
                  tab_peer[b.idx] = b.peer;
                  tab_up[b.idx]   = b.up;
                  tab_loop[b.idx] = b.loopback;
                  tab_ptp[b.idx]  = b.ptp;
               end
               OP_CLASSIFY: want.cls = classify_addr(b.query);
               OP_FIND: want = locate_iface(b.query);
               default: want = '0;
            endcase
            expected_rsp.push_back(want);
         end
         req_fire <= req_valid && req_ch.ready;
      end
   end

   // request driver
   always @(negedge clock) begin
      req_beat_t nxt;
      if (!reset && !(req_valid && !req_fire)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_req.size() != 0) begin
            nxt = pending_req.pop_front();
            req_beat  <= nxt;
            req_valid <= 1'b1;
            req_gap = pick_gap(calm_req);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap(calm_rsp);
         end
      end
   end

   function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
      if (len == 0) return '0;
      return ALL_ONES << (32 - len);
   endfunction

   task automatic add_write(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] a,
                            input logic [ADDR_W-1:0] m, input logic [ADDR_W-1:0] p,
                            input logic up, input logic lb, input logic ptp);
      req_beat_t b;
      b.op = OP_WRITE;
      b.idx = idx;
      b.addr = a;
      b.mask = m;
      b.peer = p;
      b.up = up;
      b.loopback = lb;
      b.ptp = ptp;
      b.query = $urandom;
      gen_addr[idx] = a;
      gen_mask[idx] = m;
      gen_peer[idx] = p;
      pending_req.push_back(b);
   endtask

   task automatic add_query(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] q);
      req_beat_t b;
      b.op = op;
      b.idx = IDX_W'($urandom);
      b.addr = $urandom;
      b.mask = $urandom;
      b.peer = $urandom;
      b.up = 1'($urandom);
      b.loopback = 1'($urandom);
      b.ptp = 1'($urandom);
      b.query = q;
      pending_req.push_back(b);
   endtask

   function automatic logic [ADDR_W-1:0] aim_query();
      int unsigned       i;
      logic [ADDR_W-1:0] a, m;
      i = $urandom_range(0, NUM_IFACES - 1);
      a = gen_addr[i];
      m = gen_mask[i];
      case ($urandom_range(0, 11))
         0: return a;
         1: return a & m;
         2: return a | ~m;
         3: return a | classful_host(a);
         4: return gen_peer[i];
         5: return (a & m) | ($urandom & ~m);
         6: return '0;
         7: return ALL_ONES;
         8: return {LOOP_NET, 24'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic add_random_write();
      logic [ADDR_W-1:0] a, m, p;
      int unsigned       r;
      r = $urandom_range(0, 99);
      if (r < 10) a = '0;
      else if (r < 30) a = (gen_addr[$urandom_range(0, NUM_IFACES - 1)] & 32'hFFFF_FF00)
                           | 32'($urandom_range(0, 255));
      else a = $urandom;
      if ($urandom_range(0, 9) < 7) m = prefix_mask($urandom_range(0, 32));
      else m = $urandom;
      if ($urandom_range(0, 1) == 0) p = $urandom;
      else p = aim_query();
      add_write(IDX_W'($urandom), a, m, p, $urandom_range(0, 9) < 8,
                $urandom_range(0, 9) < 3, $urandom_range(0, 9) < 3);
   endtask

   initial begin
      int unsigned r;
      for (int i = 0; i < NUM_IFACES; i++) begin
         gen_addr[i] = '0;
         gen_mask[i] = '0;
         gen_peer[i] = '0;
      end

      // empty table: fixed cases and a miss
      add_query(OP_CLASSIFY, '0);
      add_query(OP_CLASSIFY, ALL_ONES);
      add_query(OP_CLASSIFY, 32'h7F00_0001);
      add_query(OP_FIND, 32'h0A01_0203);
      // class A subnet: own address, zero host, all-ones host, none
      add_write(3'd0, 32'h0A01_0203, 32'hFF00_0000, 32'h0, 1'b1, 1'b0, 1'b0);
      add_query(OP_CLASSIFY, 32'h0A01_0203);
      add_query(OP_CLASSIFY, 32'h0A00_0000);
      add_query(OP_CLASSIFY, 32'h0AFF_FFFF);
      add_query(OP_CLASSIFY, 32'h0A01_0204);
      // class B classful broadcast off the subnet
      add_write(3'd1, 32'hAC10_0501, 32'hFFFF_FF00, 32'h0, 1'b1, 1'b0, 1'b0);
      add_query(OP_CLASSIFY, 32'hAC10_FFFF);
      // point-to-point link, class C classful broadcast
      add_write(3'd2, 32'hC801_0101, 32'hFFFF_0000, 32'h0102_0304, 1'b1, 1'b0, 1'b1);
      add_query(OP_FIND, 32'h0102_0304);
      add_query(OP_CLASSIFY, 32'hC801_01FF);
      // class D handled as class C
      add_write(3'd3, 32'hE000_0005, ALL_ONES, 32'h0, 1'b1, 1'b0, 1'b0);
      add_query(OP_CLASSIFY, 32'hE000_00FF);
      // loopback entry matches only its own address
      add_write(3'd4, 32'h3200_0001, 32'h0, 32'h0, 1'b1, 1'b1, 1'b0);
      add_query(OP_FIND, 32'h3200_0001);
      add_query(OP_FIND, 32'h3200_0002);
      add_query(OP_FIND, 32'h0A09_0909);
      // up entry with zero address owns everything
      add_write(3'd5, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0);
      add_query(OP_CLASSIFY, 32'h0808_0808);
      add_write(3'd6, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0);
      add_query(OP_CLASSIFY, 32'h0808_0808);
      add_query(OP_FIND, 32'h0808_0808);
      // all ones in every field, and the unused operation code
      add_write(3'd7, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 1'b1, 1'b1);
      add_query(OP_FIND, ALL_ONES);
      add_query(OP_UNUSED, ALL_ONES);
      add_query(OP_UNUSED, '0);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         r = $urandom_range(0, 99);
         if (r < 28) add_random_write();
         else if (r < 63) add_query(OP_CLASSIFY, aim_query());
         else if (r < 95) add_query(OP_FIND, aim_query());
         else add_query(OP_UNUSED, $urandom);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_req.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS ip_local_address_classifier");
      end else begin
         $display("FAIL ip_local_address_classifier");
      end
      $finish;
   end

   initial begin
      #TIME_LIMIT;
      $display("%0t: timeout, %0d result beats outstanding", $time, expected_rsp.size());
      $display("FAIL ip_local_address_classifier");
      $finish;
   end

endmodule

/* sim.f */
design/lac_pkg.sv
design/lac_req_if.sv
design/lac_rsp_if.sv
design/lac_front.sv
design/lac_queue.sv
design/lac_back.sv
design/ip_local_address_classifier.sv
sim/tb_ip_local_address_classifier.sv
